// ===== sv/vspc_pkg.sv =====
package vspc_pkg;

  // Field widths of the item, result and config ports.
  localparam int unsigned CharW  = 8;
  localparam int unsigned MajorW = 6;
  localparam int unsigned MinorW = 6;
  localparam int unsigned PatchW = 4;
  localparam int unsigned CfgW   = 6;

  // Working width of a number while it is parsed (two decimal digits).
  localparam int unsigned NumW = 7;

  // Three numbers make up a version: major, minor and patch.
  localparam int unsigned NumCount = 3;
  localparam int unsigned DoneW    = 2;

  // Number of digits per number, held as a small count.
  localparam int unsigned DigitCntW = 2;
  localparam int unsigned DigitMax  = 2;

  localparam int unsigned MaxCharsDefault = 8;
  localparam int unsigned MinChars        = 5;

  localparam int unsigned MajorLimit = 63;
  localparam int unsigned MinorLimit = 63;
  localparam int unsigned PatchLimit = 15;

  localparam logic [CharW-1:0] CharNul  = 8'h00;
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharDot  = 8'h2E;

  typedef enum logic [1:0] {
    CfgCurMajor = 2'd0,
    CfgCurMinor = 2'd1,
    CfgCurPatch = 2'd2
  } cfg_idx_e;

endpackage

// ===== sv/version_string_parse_compare_unit.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | char_byte_i, last_byte_i
// out     | output    | out_valid_o / out_ready_i  | valid_res_o, major_o, minor_o, patch_o,
//         |           |                            | is_newer_o
// cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One item is taken per cycle while in_ready_o is high; the parse state is updated on the edge that accepts it.
// The item carrying the last flag has its result written into the output register on the edge that accepts it.
// Asynchronous active-low reset clears the parse state, the current version and the output valid flag.
// A result waiting in the output register holds back further items until it is taken;
// with out_ready_i held high the block takes an item in every cycle.
module version_string_parse_compare_unit #(
  parameter int unsigned MaxChars = vspc_pkg::MaxCharsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vspc_pkg::CharW-1:0]    char_byte_i,
  input  logic                          last_byte_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          valid_res_o,
  output logic [vspc_pkg::MajorW-1:0]   major_o,
  output logic [vspc_pkg::MinorW-1:0]   minor_o,
  output logic [vspc_pkg::PatchW-1:0]   patch_o,
  output logic                          is_newer_o,

  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [vspc_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MaxChars + 1);
  localparam int unsigned NumW  = vspc_pkg::NumW;
  localparam int unsigned DoneW = vspc_pkg::DoneW;
  localparam int unsigned DcW   = vspc_pkg::DigitCntW;

  // Current installed version.
  logic [vspc_pkg::MajorW-1:0] cur_major_q;
  logic [vspc_pkg::MinorW-1:0] cur_minor_q;
  logic [vspc_pkg::PatchW-1:0] cur_patch_q;

  // Parse state.
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ended_q, ended_d;
  logic             rej_q, rej_d;
  logic             in_num_q, in_num_d;
  logic [DcW-1:0]   dc_q, dc_d;
  logic             fdz_q, fdz_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [DoneW-1:0] nd_q, nd_d;
  logic [NumW-1:0]  saved_q [vspc_pkg::NumCount];
  logic [NumW-1:0]  saved_d [vspc_pkg::NumCount];
  logic             lwd_q, lwd_d;

  // Output register.
  logic                        out_valid_q;
  logic                        res_valid_q, res_valid_d;
  logic [vspc_pkg::MajorW-1:0] major_q, major_d;
  logic [vspc_pkg::MinorW-1:0] minor_q, minor_d;
  logic [vspc_pkg::PatchW-1:0] patch_q, patch_d;
  logic                        newer_q, newer_d;

  logic       in_fire;
  logic       is_numeral;
  logic       is_dot;
  logic [3:0] digit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_numeral = (char_byte_i >= vspc_pkg::CharZero) &&
                      (char_byte_i <= vspc_pkg::CharNine);
  assign is_dot     = (char_byte_i == vspc_pkg::CharDot);
  assign digit      = 4'(char_byte_i - vspc_pkg::CharZero);

  always_comb begin
    logic             fin_rej;
    logic [DoneW-1:0] fin_nd;
    logic [NumW-1:0]  fin_saved [vspc_pkg::NumCount];
    logic             ok;

    cnt_d    = cnt_q;
    ended_d  = ended_q;
    rej_d    = rej_q;
    in_num_d = in_num_q;
    dc_d     = dc_q;
    fdz_d    = fdz_q;
    num_d    = num_q;
    nd_d     = nd_q;
    saved_d  = saved_q;
    lwd_d    = lwd_q;

    // Byte update until a NUL ends the string: each other character is counted, then parsed unless rejected.
    if (in_fire && !ended_q) begin
      if (char_byte_i == vspc_pkg::CharNul) begin
        ended_d = 1'b1;
      end else begin
        if (cnt_q >= CntW'(MaxChars)) begin
          rej_d = 1'b1;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (!rej_d) begin
          if (!is_numeral && !is_dot) begin
            rej_d = 1'b1;
          end else if (!in_num_q && nd_q == DoneW'(vspc_pkg::NumCount)) begin
            rej_d = 1'b1;
          end else if (cnt_q == '0 && !is_numeral) begin
            rej_d = 1'b1;
          end else if (in_num_q && is_numeral && dc_q >= DcW'(vspc_pkg::DigitMax)) begin
            rej_d = 1'b1;
          end else if (in_num_q && is_numeral && fdz_q) begin
            // A second digit after a leading zero.
            rej_d = 1'b1;
          end else begin
            if (in_num_q && is_dot) begin
              if (nd_q < DoneW'(vspc_pkg::NumCount)) begin
                saved_d[nd_q] = num_q;
                nd_d          = nd_q + DoneW'(1);
              end else begin
                rej_d = 1'b1;
              end
              in_num_d = 1'b0;
              dc_d     = '0;
              fdz_d    = 1'b0;
              num_d    = '0;
            end else if (!in_num_q && is_numeral) begin
              fdz_d    = (char_byte_i == vspc_pkg::CharZero);
              dc_d     = DcW'(1);
              num_d    = NumW'(digit);
              in_num_d = 1'b1;
            end else if (in_num_q && is_numeral) begin
              num_d = num_q * NumW'(10) + NumW'(digit);
              dc_d  = DcW'(vspc_pkg::DigitMax);
            end
            lwd_d = is_dot;
          end
        end
      end
    end

    // End of string: close an open number and judge the whole version.
    fin_rej   = rej_d;
    fin_nd    = nd_d;
    fin_saved = saved_d;
    if (!rej_d && in_num_d) begin
      if (nd_d < DoneW'(vspc_pkg::NumCount)) begin
        fin_saved[nd_d] = num_d;
        fin_nd          = nd_d + DoneW'(1);
      end else begin
        fin_rej = 1'b1;
      end
    end

    ok = !fin_rej
      && cnt_d >= CntW'(vspc_pkg::MinChars)
      && cnt_d <= CntW'(MaxChars)
      && !lwd_d
      && fin_nd == DoneW'(vspc_pkg::NumCount)
      && fin_saved[0] <= NumW'(vspc_pkg::MajorLimit)
      && fin_saved[1] <= NumW'(vspc_pkg::MinorLimit)
      && fin_saved[2] <= NumW'(vspc_pkg::PatchLimit);

    res_valid_d = ok;
    major_d     = ok ? vspc_pkg::MajorW'(fin_saved[0]) : '0;
    minor_d     = ok ? vspc_pkg::MinorW'(fin_saved[1]) : '0;
    patch_d     = ok ? vspc_pkg::PatchW'(fin_saved[2]) : '0;
    if (!ok) begin
      newer_d = 1'b0;
    end else if (major_d != cur_major_q) begin
      newer_d = major_d > cur_major_q;
    end else if (minor_d != cur_minor_q) begin
      newer_d = minor_d > cur_minor_q;
    end else begin
      newer_d = patch_d > cur_patch_q;
    end

    // The last item starts the next string from a clean state.
    if (in_fire && last_byte_i) begin
      cnt_d    = '0;
      ended_d  = 1'b0;
      rej_d    = 1'b0;
      in_num_d = 1'b0;
      dc_d     = '0;
      fdz_d    = 1'b0;
      num_d    = '0;
      nd_d     = '0;
      lwd_d    = 1'b0;
      for (int i = 0; i < vspc_pkg::NumCount; i++) begin
        saved_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ended_q  <= 1'b0;
      rej_q    <= 1'b0;
      in_num_q <= 1'b0;
      dc_q     <= '0;
      fdz_q    <= 1'b0;
      num_q    <= '0;
      nd_q     <= '0;
      lwd_q    <= 1'b0;
      for (int i = 0; i < vspc_pkg::NumCount; i++) begin
        saved_q[i] <= '0;
      end
    end else begin
      cnt_q    <= cnt_d;
      ended_q  <= ended_d;
      rej_q    <= rej_d;
      in_num_q <= in_num_d;
      dc_q     <= dc_d;
      fdz_q    <= fdz_d;
      num_q    <= num_d;
      nd_q     <= nd_d;
      lwd_q    <= lwd_d;
      saved_q  <= saved_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_major_q <= '0;
      cur_minor_q <= '0;
      cur_patch_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vspc_pkg::CfgCurMajor: cur_major_q <= vspc_pkg::MajorW'(cfg_data_i);
        vspc_pkg::CfgCurMinor: cur_minor_q <= vspc_pkg::MinorW'(cfg_data_i);
        vspc_pkg::CfgCurPatch: cur_patch_q <= vspc_pkg::PatchW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      res_valid_q <= res_valid_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      patch_q     <= patch_d;
      newer_q     <= newer_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_valid_q;
  assign major_o     = major_q;
  assign minor_o     = minor_q;
  assign patch_o     = patch_q;
  assign is_newer_o  = newer_q;

endmodule
